### hdl/hrfp_pkg.sv
// Shared types and constants of the H.264 RTP FU-A packetiser.
`default_nettype none

package hrfp_pkg;

    // Largest packet on the wire and largest FU-A payload per fragment.
    localparam int unsigned MAX_PACKET = 1400;
    localparam int unsigned FRAG_MAX   = MAX_PACKET - 18;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ILV_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ILV_CH  = 2'd2;

    localparam logic [31:0] SSRC_RESET   = 32'h1234_5678;
    localparam logic [7:0]  RTP_VERSION  = 8'h80;
    localparam logic [6:0]  RTP_PT       = 7'd96;
    localparam logic [4:0]  FUA_TYPE     = 5'd28;
    localparam logic [7:0]  NRI_MASK     = 8'hE0;
    localparam logic [7:0]  ILV_MAGIC    = 8'h24;
    localparam logic [4:0]  NAL_SEI      = 5'd6;
    localparam logic [4:0]  NAL_SPS      = 5'd7;
    localparam logic [4:0]  NAL_PPS      = 5'd8;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // One queued item: a payload byte plus what the back end must emit before it.
    typedef struct packed {
        logic [7:0]  data;
        logic        pkt_end;
        logic        with_hdr;
        logic        with_fu;
        logic        ilv;
        logic        marker;
        logic [15:0] rtp_len;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
    } job_t;

    // Byte position within the packet being emitted.
    typedef enum logic [4:0] {
        ST_DOLLAR, ST_CHAN, ST_LEN_HI, ST_LEN_LO,
        ST_VER, ST_MPT, ST_SEQ_HI, ST_SEQ_LO,
        ST_TS3, ST_TS2, ST_TS1, ST_TS0,
        ST_SSRC3, ST_SSRC2, ST_SSRC1, ST_SSRC0,
        ST_FU_IND, ST_FU_HDR, ST_DATA
    } step_t;

    typedef struct packed {
        logic        ilv_en;
        logic [7:0]  ilv_ch;
        logic [31:0] ssrc;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/hrfp_front.sv
// Front end: tracks NAL unit state and turns bytes to be sent into queued jobs.
`default_nettype none

module hrfp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          take,
    input  wire logic [7:0]    data_byte,
    input  wire logic          unit_first,
    input  wire logic [23:0]   unit_length,
    input  wire logic [31:0]   rtp_time,
    input  wire logic          ilv_en,
    output hrfp_pkg::job_t     job,
    output logic               job_push
);

    logic [15:0] seq_reg,        seq_next;
    logic        frag_mode_reg,  frag_mode_next;
    logic [7:0]  hdr_reg,        hdr_next;
    logic [23:0] rem_reg,        rem_next;
    logic [13:0] fill_reg,       fill_next;
    logic        first_frag_reg, first_frag_next;
    logic [31:0] ts_reg,         ts_next;

    logic        job_en;
    logic        fits;
    logic        last_frag;
    logic [23:0] rem_m1;
    logic [13:0] fill_inc;
    logic [15:0] flen;
    logic [4:0]  unit_kind;

    assign fits      = ({1'b0, unit_length} + 25'd16) <= 25'(hrfp_pkg::MAX_PACKET);
    assign last_frag = rem_reg <= 24'(hrfp_pkg::FRAG_MAX);
    assign flen      = last_frag ? rem_reg[15:0] : 16'(hrfp_pkg::FRAG_MAX);
    assign rem_m1    = rem_reg - 24'd1;
    assign fill_inc  = fill_reg + 14'd1;
    assign unit_kind = data_byte[4:0];

    always_comb begin
        seq_next        = seq_reg;
        frag_mode_next  = frag_mode_reg;
        hdr_next        = hdr_reg;
        rem_next        = rem_reg;
        fill_next       = fill_reg;
        first_frag_next = first_frag_reg;
        ts_next         = ts_reg;

        job_en       = 1'b0;
        job.data     = data_byte;
        job.pkt_end  = 1'b0;
        job.with_hdr = 1'b0;
        job.with_fu  = 1'b0;
        job.ilv      = ilv_en;
        job.marker   = 1'b0;
        job.rtp_len  = 16'd0;
        job.seq      = seq_reg;
        job.ts       = ts_reg;
        job.fu_ind   = (hdr_reg & hrfp_pkg::NRI_MASK) | {3'b000, hrfp_pkg::FUA_TYPE};
        job.fu_hdr   = {first_frag_reg, last_frag, 1'b0, hdr_reg[4:0]};

        if (unit_first) begin
            if (unit_length != 24'd0) begin
                ts_next         = rtp_time;
                hdr_next        = data_byte;
                fill_next       = 14'd0;
                first_frag_next = 1'b1;
                rem_next        = unit_length - 24'd1;
                if (fits) begin
                    // The whole unit goes out as one packet headed by this byte.
                    frag_mode_next = 1'b0;
                    job_en         = 1'b1;
                    job.with_hdr   = 1'b1;
                    job.marker     = !(unit_kind == hrfp_pkg::NAL_SEI ||
                                       unit_kind == hrfp_pkg::NAL_SPS ||
                                       unit_kind == hrfp_pkg::NAL_PPS);
                    job.rtp_len    = unit_length[15:0] + 16'd12;
                    job.pkt_end    = (unit_length == 24'd1);
                    job.ts         = rtp_time;
                    seq_next       = seq_reg + 16'd1;
                end else begin
                    frag_mode_next = 1'b1;
                end
            end
        end else if (rem_reg != 24'd0) begin
            job_en   = 1'b1;
            rem_next = rem_m1;
            if (frag_mode_reg) begin
                if (fill_reg == 14'd0) begin
                    job.with_hdr    = 1'b1;
                    job.with_fu     = 1'b1;
                    job.marker      = last_frag;
                    job.rtp_len     = flen + 16'd14;
                    seq_next        = seq_reg + 16'd1;
                    first_frag_next = 1'b0;
                end
                job.pkt_end = (rem_m1 == 24'd0) || (fill_inc >= 14'(hrfp_pkg::FRAG_MAX));
                fill_next   = job.pkt_end ? 14'd0 : fill_inc;
            end else begin
                job.pkt_end = (rem_m1 == 24'd0);
            end
        end
    end

    assign job_push = take & job_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= 16'd0;
            frag_mode_reg  <= 1'b0;
            hdr_reg        <= 8'd0;
            rem_reg        <= 24'd0;
            fill_reg       <= 14'd0;
            first_frag_reg <= 1'b1;
            ts_reg         <= 32'd0;
        end else if (take) begin
            seq_reg        <= seq_next;
            frag_mode_reg  <= frag_mode_next;
            hdr_reg        <= hdr_next;
            rem_reg        <= rem_next;
            fill_reg       <= fill_next;
            first_frag_reg <= first_frag_next;
            ts_reg         <= ts_next;
        end
    end

endmodule

`default_nettype wire

### hdl/hrfp_fifo.sv
// Short job queue between the front and back ends.
`default_nettype none

module hrfp_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire hrfp_pkg::job_t  push_job,
    input  wire logic            pop,
    output hrfp_pkg::job_t       head,
    output logic                 empty,
    output logic                 full
);

    localparam int unsigned PW = hrfp_pkg::FIFO_PTR_W;

    hrfp_pkg::job_t   mem [hrfp_pkg::FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg,  count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PW+1)'(hrfp_pkg::FIFO_DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### hdl/hrfp_back.sv
// Back end: expands queued jobs into packet bytes behind an output register.
`default_nettype none

module hrfp_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hrfp_pkg::job_t  head,
    input  wire logic            empty,
    output logic                 pop,
    input  wire hrfp_pkg::cfg_t  cfg,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic [1:0]           m_tuser
);

    hrfp_pkg::step_t step_reg, step_next, cur_step;
    logic            busy_reg, busy_next;
    logic            fire;
    logic            out_ready;

    logic            m_tvalid_reg;
    logic [7:0]      byte_reg, byte_next;
    logic            end_reg, end_next;
    logic            start_reg, start_next;
    logic            last_reg, last_next;

    assign out_ready = !m_tvalid_reg || m_tready;
    assign fire      = !empty && out_ready;

    // Where a fresh job begins: prefix, RTP header or straight at the payload byte.
    always_comb begin
        if (busy_reg) begin
            cur_step = step_reg;
        end else if (!head.with_hdr) begin
            cur_step = hrfp_pkg::ST_DATA;
        end else if (head.ilv) begin
            cur_step = hrfp_pkg::ST_DOLLAR;
        end else begin
            cur_step = hrfp_pkg::ST_VER;
        end
    end

    // Next state.
    always_comb begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (fire) begin
            unique case (cur_step)
                hrfp_pkg::ST_DATA: begin
                    busy_next = 1'b0;
                end
                hrfp_pkg::ST_SSRC0: begin
                    busy_next = 1'b1;
                    step_next = head.with_fu ? hrfp_pkg::ST_FU_IND : hrfp_pkg::ST_DATA;
                end
                default: begin
                    busy_next = 1'b1;
                    step_next = hrfp_pkg::step_t'(5'(cur_step) + 5'd1);
                end
            endcase
        end
    end

    // Outputs.
    always_comb begin
        pop        = fire && (cur_step == hrfp_pkg::ST_DATA);
        start_next = (cur_step == hrfp_pkg::ST_DOLLAR) ||
                     (cur_step == hrfp_pkg::ST_VER && !head.ilv);
        end_next   = (cur_step == hrfp_pkg::ST_DATA) && head.pkt_end;
        last_next  = (cur_step == hrfp_pkg::ST_DATA);
        unique case (cur_step)
            hrfp_pkg::ST_DOLLAR: byte_next = hrfp_pkg::ILV_MAGIC;
            hrfp_pkg::ST_CHAN:   byte_next = cfg.ilv_ch;
            hrfp_pkg::ST_LEN_HI: byte_next = head.rtp_len[15:8];
            hrfp_pkg::ST_LEN_LO: byte_next = head.rtp_len[7:0];
            hrfp_pkg::ST_VER:    byte_next = hrfp_pkg::RTP_VERSION;
            hrfp_pkg::ST_MPT:    byte_next = {head.marker, hrfp_pkg::RTP_PT};
            hrfp_pkg::ST_SEQ_HI: byte_next = head.seq[15:8];
            hrfp_pkg::ST_SEQ_LO: byte_next = head.seq[7:0];
            hrfp_pkg::ST_TS3:    byte_next = head.ts[31:24];
            hrfp_pkg::ST_TS2:    byte_next = head.ts[23:16];
            hrfp_pkg::ST_TS1:    byte_next = head.ts[15:8];
            hrfp_pkg::ST_TS0:    byte_next = head.ts[7:0];
            hrfp_pkg::ST_SSRC3:  byte_next = cfg.ssrc[31:24];
            hrfp_pkg::ST_SSRC2:  byte_next = cfg.ssrc[23:16];
            hrfp_pkg::ST_SSRC1:  byte_next = cfg.ssrc[15:8];
            hrfp_pkg::ST_SSRC0:  byte_next = cfg.ssrc[7:0];
            hrfp_pkg::ST_FU_IND: byte_next = head.fu_ind;
            hrfp_pkg::ST_FU_HDR: byte_next = head.fu_hdr;
            hrfp_pkg::ST_DATA:   byte_next = head.data;
            default:             byte_next = head.data;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= hrfp_pkg::ST_DATA;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_reg  <= byte_next;
            end_reg   <= end_next;
            start_reg <= start_next;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = end_reg;
    assign m_tuser  = {last_reg, start_reg};

endmodule

`default_nettype wire

### hdl/h264_rtp_fua_packetizer_top.sv
// Top level of the H.264 RTP packetiser with FU-A fragmentation.
//
//  Channel | Direction | Handshake          | Item
//  s_      | in        | s_tvalid/s_tready  | one NAL unit byte with unit length and timestamp
//  m_      | out       | m_tvalid/m_tready  | one RTP packet byte with start/end/run flags
//  cfg_    | in        | cfg_we (no ready)  | write of SSRC, prefix enable or prefix channel
//
// A byte that opens a packet follows the optional prefix, the RTP header and, in a fragment,
// the FU bytes; the back end emits one header byte per cycle from the queue head unless stalled.
// The front end accepts an item every cycle while the four-entry job queue has room.
// A fragmented unit's header byte and stray bytes are consumed without using the queue.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none

module h264_rtp_fua_packetizer_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [63:0]                       s_tdata,  // data_byte, unit_length, rtp_time
    input  wire logic                              s_tuser,  // unit_first
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,  // packet_byte
    output logic                                   m_tlast,  // packet_end
    output logic [1:0]                             m_tuser,  // packet_start, run_last
    input  wire logic                              cfg_we,
    input  wire logic [hrfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hrfp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    hrfp_pkg::cfg_t cfg_reg;
    hrfp_pkg::job_t new_job;
    hrfp_pkg::job_t head_job;
    logic           take;
    logic           job_push;
    logic           job_pop;
    logic           q_empty;
    logic           q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ssrc   <= hrfp_pkg::SSRC_RESET;
            cfg_reg.ilv_en <= 1'b0;
            cfg_reg.ilv_ch <= 8'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hrfp_pkg::CFG_SSRC:   cfg_reg.ssrc   <= cfg_wdata;
                hrfp_pkg::CFG_ILV_EN: cfg_reg.ilv_en <= cfg_wdata[0];
                hrfp_pkg::CFG_ILV_CH: cfg_reg.ilv_ch <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    hrfp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .data_byte   (s_tdata[7:0]),
        .unit_first  (s_tuser),
        .unit_length (s_tdata[31:8]),
        .rtp_time    (s_tdata[63:32]),
        .ilv_en      (cfg_reg.ilv_en),
        .job         (new_job),
        .job_push    (job_push)
    );

    hrfp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (new_job),
        .pop      (job_pop),
        .head     (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    hrfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_job),
        .empty    (q_empty),
        .pop      (job_pop),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### tb/hrfp_packet_checker.sv
// Watches both streams of the packetiser, predicts every packet byte and compares.
`default_nettype none

module hrfp_packet_checker
    import hrfp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [63:0]            s_tdata,  // data_byte, unit_length, rtp_time
    input  wire logic                   s_tuser,  // unit_first
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [7:0]             m_tdata,  // packet_byte
    input  wire logic                   m_tlast,  // packet_end
    input  wire logic [1:0]             m_tuser,  // packet_start, run_last
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int unsigned                 fail_count,
    output int unsigned                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SSRC_AT_RESET = 32'h1234_5678;
    localparam logic [7:0]  RTP_V2        = 8'h80;
    localparam logic [6:0]  RTP_PAYLOAD   = 7'd96;
    localparam logic [4:0]  FU_A          = 5'd28;
    localparam logic [7:0]  DOLLAR        = 8'h24;
    localparam logic [4:0]  UNIT_SEI      = 5'd6;
    localparam logic [4:0]  UNIT_SPS      = 5'd7;
    localparam logic [4:0]  UNIT_PPS      = 5'd8;
    localparam int unsigned FRAG_PAYLOAD  = MAX_PACKET - 18;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_start;
        logic       pkt_end;
        logic       run_last;
    } pkt_byte_t;

    pkt_byte_t expected_bytes[$];
    pkt_byte_t burst[$];

    logic [31:0] ssrc_reg;
    logic        ilv_en_reg;
    logic [7:0]  ilv_ch_reg;

    logic [15:0] seq_num;
    logic        frag_mode;
    logic [7:0]  nal_hdr;
    logic [23:0] remaining;
    logic [13:0] frag_fill;
    logic        first_frag;
    logic [31:0] unit_ts;

    int unsigned failures;

    function automatic void emit(input logic [7:0] value, input logic opener,
                                 input logic stop);
        burst.push_back('{data: value, pkt_start: opener, pkt_end: stop, run_last: 1'b0});
    endfunction

    function automatic void emit_header(input logic [15:0] rtp_len, input logic marker);
        logic opener;
        opener = 1'b1;
        if (ilv_en_reg) begin
            emit(DOLLAR, 1'b1, 1'b0);
            emit(ilv_ch_reg, 1'b0, 1'b0);
            emit(rtp_len[15:8], 1'b0, 1'b0);
            emit(rtp_len[7:0], 1'b0, 1'b0);
            opener = 1'b0;
        end
        emit(RTP_V2, opener, 1'b0);
        emit({marker, RTP_PAYLOAD}, 1'b0, 1'b0);
        emit(seq_num[15:8], 1'b0, 1'b0);
        emit(seq_num[7:0], 1'b0, 1'b0);
        emit(unit_ts[31:24], 1'b0, 1'b0);
        emit(unit_ts[23:16], 1'b0, 1'b0);
        emit(unit_ts[15:8], 1'b0, 1'b0);
        emit(unit_ts[7:0], 1'b0, 1'b0);
        emit(ssrc_reg[31:24], 1'b0, 1'b0);
        emit(ssrc_reg[23:16], 1'b0, 1'b0);
        emit(ssrc_reg[15:8], 1'b0, 1'b0);
        emit(ssrc_reg[7:0], 1'b0, 1'b0);
        seq_num = seq_num + 16'd1;
    endfunction

    // Works out the packet bytes that one accepted unit byte releases.
    function automatic void packetise(input logic [7:0] value, input logic opener,
                                      input logic [23:0] len, input logic [31:0] stamp);
        logic        marker;
        logic        closing;
        logic        stop;
        int unsigned flen;
        pkt_byte_t   tail;
        burst.delete();
        if (opener) begin
            if (len != 0) begin
                unit_ts    = stamp;
                nal_hdr    = value;
                frag_fill  = '0;
                first_frag = 1'b1;
                if (int'(len) + 16 <= int'(MAX_PACKET)) begin
                    marker = !(value[4:0] == UNIT_SEI || value[4:0] == UNIT_SPS
                               || value[4:0] == UNIT_PPS);
                    frag_mode = 1'b0;
                    remaining = len;
                    emit_header(16'(int'(len) + 12), marker);
                    remaining = remaining - 24'd1;
                    emit(value, 1'b0, remaining == 0);
                end else begin
                    // The header byte of a fragmented unit is held back for the FU bytes.
                    frag_mode = 1'b1;
                    remaining = len - 24'd1;
                end
            end
        end else if (remaining != 0) begin
            if (frag_mode) begin
                if (frag_fill == 0) begin
                    closing = (int'(remaining) <= int'(FRAG_PAYLOAD));
                    flen = closing ? int'(remaining) : FRAG_PAYLOAD;
                    emit_header(16'(flen + 14), closing);
                    emit({nal_hdr[7:5], FU_A}, 1'b0, 1'b0);
                    emit({first_frag, closing, 1'b0, nal_hdr[4:0]}, 1'b0, 1'b0);
                    first_frag = 1'b0;
                end
                frag_fill = frag_fill + 14'd1;
                remaining = remaining - 24'd1;
                stop = (remaining == 0) || (int'(frag_fill) >= int'(FRAG_PAYLOAD));
                emit(value, 1'b0, stop);
                if (stop) frag_fill = '0;
            end else begin
                remaining = remaining - 24'd1;
                emit(value, 1'b0, remaining == 0);
            end
        end
        if (burst.size() != 0) begin
            tail = burst.pop_back();
            tail.run_last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[k]) expected_bytes.push_back(burst[k]);
    endfunction

    always @(posedge aclk) begin : watch
        pkt_byte_t want;
        pkt_byte_t got;
        if (!aresetn) begin
            ssrc_reg   = SSRC_AT_RESET;
            ilv_en_reg = 1'b0;
            ilv_ch_reg = '0;
            seq_num    = '0;
            frag_mode  = 1'b0;
            nal_hdr    = '0;
            remaining  = '0;
            frag_fill  = '0;
            first_frag = 1'b1;
            unit_ts    = '0;
            expected_bytes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SSRC:   ssrc_reg = cfg_wdata[31:0];
                    CFG_ILV_EN: ilv_en_reg = cfg_wdata[0];
                    CFG_ILV_CH: ilv_ch_reg = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                packetise(s_tdata[7:0], s_tuser, s_tdata[31:8], s_tdata[63:32]);
            end
            if (m_tvalid && m_tready) begin
                got = '{data: m_tdata, pkt_start: m_tuser[0], pkt_end: m_tlast,
                        run_last: m_tuser[1]};
                if (expected_bytes.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("%0t: unexpected byte %02h start %b end %b run_last %b",
                                 $realtime, got.data, got.pkt_start, got.pkt_end,
                                 got.run_last);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            // Each value is byte/start/end/run_last.
                            $display("%0t: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                                     $realtime, want.data, want.pkt_start, want.pkt_end,
                                     want.run_last, got.data, got.pkt_start, got.pkt_end,
                                     got.run_last);
                        end
                    end
                end
            end
        end
        pending    <= expected_bytes.size();
        fail_count <= failures;
    end

endmodule

`default_nettype wire

### tb/testbench.sv
// Top of the packetiser testbench: clock, reset, stimulus, receiver and verdict.
`default_nettype none

module testbench;
    import hrfp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned PHASE_UNITS   = 8;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata = '0;   // data_byte, unit_length, rtp_time
    logic                  s_tuser = 1'b0; // unit_first
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // packet_byte
    logic                  m_tlast;        // packet_end
    logic [1:0]            m_tuser;        // packet_start, run_last
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int unsigned fail_count;
    int unsigned pending;
    bit          squeeze_req = 1'b0;

    h264_rtp_fua_packetizer_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    hrfp_packet_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #30_000_000;
        $display("h264_rtp_fua_packetizer_top test failed");
        $finish;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_run();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 12);
        return $urandom_range(30, 200);
    endfunction

    // Receiver: alternating ready stretches and stalls, plus one long hold-off on request.
    always @(posedge aclk) begin : receiver
        int unsigned ready_left;
        int unsigned stall_left;
        int unsigned hold_left;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            ready_left = 0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (stall_left == 0 && ready_left == 0) begin
                stall_left = pick_gap();
                ready_left = pick_run();
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                ready_left--;
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] value, input logic opener,
                             input logic [23:0] len, input logic [31:0] stamp,
                             input bit steady);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, len, value};
        s_tuser  <= opener;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Header byte followed by count-1 body bytes; fewer than len bytes leaves it unfinished.
    task automatic send_unit(input logic [7:0] nal_hdr, input logic [23:0] len,
                             input int unsigned count, input logic [31:0] stamp,
                             input bit steady);
        send_item(nal_hdr, 1'b1, len, stamp, steady);
        for (int unsigned k = 1; k < count; k++) begin
            send_item(8'($urandom()), 1'b0, 24'($urandom()), $urandom(), steady);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every predicted byte has come out and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_units(input int unsigned quota);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        int unsigned count;
        bit          steady;
        sent = 0;
        while (sent < quota) begin
            pick   = $urandom_range(0, 99);
            steady = ($urandom_range(0, 3) == 0);
            if (pick < 60) begin
                len   = $urandom_range(1, 24);
                count = len;
            end else if (pick < 70) begin
                len   = $urandom_range(2, 40);
                count = $urandom_range(1, len - 1);
            end else if (pick < 80) begin
                // Too long for one packet: a few bytes into the first fragment, then dropped.
                len   = $urandom_range(MAX_PACKET - 15, 24'hFF_FFFF);
                count = $urandom_range(1, 8);
            end else if (pick < 88) begin
                len   = 0;
                count = 0;
                repeat ($urandom_range(1, 3)) begin
                    send_item(8'($urandom()), 1'b0, 24'($urandom()), $urandom(), steady);
                end
            end else if (pick < 93) begin
                len   = 0;
                count = 0;
                send_item(8'($urandom()), 1'b1, 24'd0, $urandom(), steady);
            end else begin
                len   = $urandom_range(25, 48);
                count = len;
            end
            if (count != 0) begin
                send_unit(8'($urandom()), 24'(len), count, $urandom(), steady);
                sent += count;
            end
        end
    endtask

    initial begin : stimulus
        do @(posedge aclk); while (!aresetn);

        // Directed part, registers at their reset values.
        send_item(8'h00, 1'b0, 24'h00_0000, 32'h0000_0000, 1'b0);
        send_item(8'hFF, 1'b1, 24'h00_0000, 32'hFFFF_FFFF, 1'b0);
        send_unit(8'h00, 24'd1, 1, 32'h0000_0000, 1'b0);
        send_unit(8'hFF, 24'd1, 1, 32'hFFFF_FFFF, 1'b0);
        send_unit(8'h67, 24'd2, 2, $urandom(), 1'b0);
        send_unit(8'h06, 24'd1, 1, $urandom(), 1'b0);
        send_unit(8'h68, 24'd1, 1, $urandom(), 1'b0);
        // A zero-length opener in the middle of a unit must leave that unit running.
        send_unit(8'h41, 24'd4, 2, $urandom(), 1'b0);
        send_item(8'h5A, 1'b1, 24'd0, $urandom(), 1'b0);
        send_item(8'hA5, 1'b0, 24'($urandom()), $urandom(), 1'b0);
        send_item(8'h3C, 1'b0, 24'($urandom()), $urandom(), 1'b0);
        send_unit(8'h21, 24'd3, 2, $urandom(), 1'b0);
        send_unit(8'h65, 24'hFF_FFFF, 4, $urandom(), 1'b0);
        send_unit(8'hC1, 24'd2, 2, $urandom(), 1'b0);
        send_item(8'hFF, 1'b0, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        settle();

        write_reg(CFG_SSRC, 32'hFFFF_FFFF);
        write_reg(CFG_ILV_EN, 32'd1);
        write_reg(CFG_ILV_CH, 32'h0000_00FF);
        random_units(PHASE_UNITS / 2);
        // Largest unit that still fits in a single packet, cut off by the next unit.
        send_unit(8'($urandom()), 24'(MAX_PACKET - 16), 3, $urandom(),
                  $urandom_range(0, 1));
        random_units(PHASE_UNITS / 2);
        settle();

        write_reg(CFG_SSRC, 32'h0000_0000);
        write_reg(CFG_ILV_EN, 32'hFFFF_FFFF);
        write_reg(CFG_ILV_CH, 32'hFFFF_FF00);
        // The receiver stops for a long while and the sender keeps pushing until it stalls.
        squeeze_req = 1'b1;
        repeat (4) send_unit(8'($urandom()), 24'($urandom_range(2, 5)), 5, $urandom(), 1'b1);
        random_units(PHASE_UNITS);
        settle();

        write_reg(CFG_SSRC, $urandom());
        write_reg(CFG_ILV_EN, 32'hFFFF_FFFE);
        write_reg(CFG_ILV_CH, $urandom());
        random_units(PHASE_UNITS / 2);
        // Smallest unit that must be fragmented, abandoned early in its first fragment.
        send_unit(8'($urandom()), 24'(MAX_PACKET - 15), 4, $urandom(),
                  $urandom_range(0, 1));
        random_units(PHASE_UNITS / 2);
        settle();

        write_reg(CFG_SSRC, $urandom());
        write_reg(CFG_ILV_EN, 32'd1);
        write_reg(CFG_ILV_CH, $urandom());
        random_units(PHASE_UNITS);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("h264_rtp_fua_packetizer_top test passed");
        end else begin
            $display("h264_rtp_fua_packetizer_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
